/* rtl/core/torus_route_and_multicast_mask_macros.svh */
// Assertion macros for the torus route and multicast mask checker.
`ifndef TORUS_ROUTE_AND_MULTICAST_MASK_MACROS_SVH
`define TORUS_ROUTE_AND_MULTICAST_MASK_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define TRM_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("trm assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define TRM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("trm assertion failed");

`endif

/* rtl/core/trm_pkg.sv */
// Package: widths, register indexes, port bit positions and shared types.
package trm_pkg;

	localparam int MAX_DIM    = 16;
	localparam int COORD_W    = 4;
	localparam int SIZE_W     = $clog2(MAX_DIM + 1);
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = SIZE_W;
	localparam int PORT_N     = 5;

	// Output port bit positions
	localparam int PORT_LOCAL = 0;
	localparam int PORT_NORTH = 1;
	localparam int PORT_SOUTH = 2;
	localparam int PORT_EAST  = 3;
	localparam int PORT_WEST  = 4;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_COORD_X     = 3'd0,
		CFG_COORD_Y     = 3'd1,
		CFG_MESH_WIDTH  = 3'd2,
		CFG_MESH_HEIGHT = 3'd3,
		CFG_NOC_SELECT  = 3'd4
	} cfg_idx_t;

	// Router configuration as seen by the route logic
	typedef struct packed {
		logic [COORD_W-1:0] coord_x;
		logic [COORD_W-1:0] coord_y;
		logic [SIZE_W-1:0]  mesh_width;
		logic [SIZE_W-1:0]  mesh_height;
		logic               noc_select;
	} cfg_t;

	// One flit header
	typedef struct packed {
		logic [COORD_W-1:0] dst_x;
		logic [COORD_W-1:0] dst_y;
		logic [COORD_W-1:0] src_x;
		logic [COORD_W-1:0] src_y;
		logic               bcast;
		logic [COORD_W-1:0] span_start_x;
		logic [COORD_W-1:0] span_start_y;
		logic [COORD_W-1:0] span_end_x;
		logic [COORD_W-1:0] span_end_y;
		logic               include_source;
		logic               column_first;
	} hdr_t;

	// One routing result
	typedef struct packed {
		logic [PORT_N-1:0] port_mask;
		logic              wrap;
	} res_t;

endpackage

/* rtl/core/trm_hdr_if.sv */
// Interface: flit header channel.
interface trm_hdr_if;
	import trm_pkg::*;

	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] dst_x;
	logic [COORD_W-1:0] dst_y;
	logic [COORD_W-1:0] src_x;
	logic [COORD_W-1:0] src_y;
	logic               bcast;
	logic [COORD_W-1:0] span_start_x;
	logic [COORD_W-1:0] span_start_y;
	logic [COORD_W-1:0] span_end_x;
	logic [COORD_W-1:0] span_end_y;
	logic               include_source;
	logic               column_first;

	modport source (
		output valid, dst_x, dst_y, src_x, src_y, bcast, span_start_x,
			span_start_y, span_end_x, span_end_y, include_source, column_first,
		input ready
	);
	modport sink (
		input valid, dst_x, dst_y, src_x, src_y, bcast, span_start_x,
			span_start_y, span_end_x, span_end_y, include_source, column_first,
		output ready
	);
endinterface

/* rtl/core/trm_route_if.sv */
// Interface: routing result channel.
interface trm_route_if;
	import trm_pkg::*;

	logic              valid;
	logic              ready;
	logic [PORT_N-1:0] port_mask;
	logic              wrap;

	modport source (output valid, port_mask, wrap, input ready);
	modport sink (input valid, port_mask, wrap, output ready);
endinterface

/* rtl/core/trm_cfg_if.sv */
// Interface: configuration register write channel.
interface trm_cfg_if;
	import trm_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/torus_route_and_multicast_mask.sv */
// Torus route and multicast mask: header register, route logic, result register.
//
// Usage:
//  - hdr   : flit header items in (valid/ready). Accepted when valid and ready are high.
//  - route : result items out (valid/ready), one per header: port_mask and wrap.
//  - cfg   : register writes (valid/ready, index, data); ready is always high.
//    Write only while no header is in flight.
// A header is held in the header register and its result in the result register,
// where it is offered on route until it is taken.
// Throughput: one header per cycle while route is not stalled; the route logic
// sits between the header register and the result register.
// Reset (arst_n low): both stages empty, coordinate 0,0, torus 1x1, network 0.
// Stall: while route.ready is low the result holds; one more header may wait in
// the header register, after which hdr.ready drops until the result is taken.
module torus_route_and_multicast_mask (
	input  logic        clk,
	input  logic        arst_n,
	trm_hdr_if.sink     hdr,
	trm_route_if.source route,
	trm_cfg_if.sink     cfg
);
	import trm_pkg::*;

	cfg_t cfg_cur;
	hdr_t hdr_in;
	hdr_t hdr_s1;
	res_t res_calc;
	res_t res_s2;
	logic valid_s1;
	logic valid_s2;
	logic adv_s1;

	trm_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cfg_out (cfg_cur)
	);

	// Gather the header fields
	assign hdr_in.dst_x          = hdr.dst_x;
	assign hdr_in.dst_y          = hdr.dst_y;
	assign hdr_in.src_x          = hdr.src_x;
	assign hdr_in.src_y          = hdr.src_y;
	assign hdr_in.bcast          = hdr.bcast;
	assign hdr_in.span_start_x   = hdr.span_start_x;
	assign hdr_in.span_start_y   = hdr.span_start_y;
	assign hdr_in.span_end_x     = hdr.span_end_x;
	assign hdr_in.span_end_y     = hdr.span_end_y;
	assign hdr_in.include_source = hdr.include_source;
	assign hdr_in.column_first   = hdr.column_first;

	// Flow control: a stage loads when it is empty or draining
	assign adv_s1    = !valid_s2 || route.ready;
	assign hdr.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (hdr.ready)
				valid_s1 <= hdr.valid;
			if (adv_s1)
				valid_s2 <= valid_s1;
		end
	end

	// Header register
	always_ff @(posedge clk) begin
		if (hdr.valid && hdr.ready)
			hdr_s1 <= hdr_in;
	end

	trm_route_calc u_route_calc (
		.hdr (hdr_s1),
		.cfg (cfg_cur),
		.res (res_calc)
	);

	// Result register
	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1)
			res_s2 <= res_calc;
	end

	assign route.valid     = valid_s2;
	assign route.port_mask = res_s2.port_mask;
	assign route.wrap      = res_s2.wrap;
endmodule

/* rtl/core/trm_cfg_regs.sv */
// Configuration register file: router coordinate, torus size, network select.
module trm_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	trm_cfg_if.sink                        cfg,
	output trm_pkg::cfg_t                  cfg_out
);
	import trm_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign cfg_out   = regs_q;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.coord_x     <= '0;
			regs_q.coord_y     <= '0;
			regs_q.mesh_width  <= SIZE_W'(1);
			regs_q.mesh_height <= SIZE_W'(1);
			regs_q.noc_select  <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_COORD_X:     regs_q.coord_x     <= cfg.data[COORD_W-1:0];
				CFG_COORD_Y:     regs_q.coord_y     <= cfg.data[COORD_W-1:0];
				CFG_MESH_WIDTH:  regs_q.mesh_width  <= cfg.data[SIZE_W-1:0];
				CFG_MESH_HEIGHT: regs_q.mesh_height <= cfg.data[SIZE_W-1:0];
				CFG_NOC_SELECT:  regs_q.noc_select  <= cfg.data[0];
				default: ;
			endcase
		end
	end
endmodule

/* rtl/core/trm_route_calc.sv */
// Route logic: unicast port and wrap, broadcast rectangle mask.
module trm_route_calc (
	input  trm_pkg::hdr_t hdr,
	input  trm_pkg::cfg_t cfg,
	output trm_pkg::res_t res
);
	import trm_pkg::*;

	// Wrapping span test: start <= end is a plain range, else it wraps
	function automatic logic in_span(logic [COORD_W-1:0] lo, logic [COORD_W-1:0] hi,
			logic [COORD_W-1:0] v);
		if (lo <= hi)
			return (v >= lo) && (v <= hi);
		return (v >= lo) || (v <= hi);
	endfunction

	// Position of a coordinate on a ring of the given size (coordinate mod size)
	function automatic logic [COORD_W-1:0] ring_pos(logic [COORD_W-1:0] here,
			logic [SIZE_W-1:0] size);
		logic [8:0]         lo;
		logic [8:0]         hi;
		logic [COORD_W-1:0] r;
		r = '0;
		for (int q = 0; q < MAX_DIM; q++) begin
			lo = 9'(q) * 9'(size);
			hi = lo + 9'(size);
			if ((9'(here) >= lo) && (9'(here) < hi))
				r = COORD_W'(9'(here) - lo);
		end
		return r;
	endfunction

	// Some ring position other than our own lies inside the span
	function automatic logic ahead(logic [COORD_W-1:0] here, logic [COORD_W-1:0] lo,
			logic [COORD_W-1:0] hi, logic [SIZE_W-1:0] size);
		logic [COORD_W-1:0] pos;
		logic               hit;
		pos = ring_pos(here, size);
		hit = 1'b0;
		for (int p = 0; p < MAX_DIM; p++) begin
			if ((SIZE_W'(p) < size) && (COORD_W'(p) != pos) &&
					in_span(lo, hi, COORD_W'(p)))
				hit = 1'b1;
		end
		return hit;
	endfunction

	logic [SIZE_W-1:0] w;
	logic [SIZE_W-1:0] h;
	logic [SIZE_W-1:0] w_last;
	logic [SIZE_W-1:0] h_last;
	logic              net1;
	logic              at_dst;
	logic              ix;
	logic              iy;
	logic              xa;
	logic              ya;
	logic              at_src;
	logic              x_fwd;
	logic              y_fwd;
	logic [PORT_N-1:0] uni_mask;
	logic              uni_wrap;
	logic [PORT_N-1:0] bc_mask;

	// Ring sizes saturate at the largest supported dimension
	assign w      = (cfg.mesh_width > SIZE_W'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : cfg.mesh_width;
	assign h      = (cfg.mesh_height > SIZE_W'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : cfg.mesh_height;
	assign w_last = w - SIZE_W'(1);
	assign h_last = h - SIZE_W'(1);
	assign net1   = cfg.noc_select;

	// Unicast: one port, wrap when leaving the ring edge
	assign at_dst = (hdr.dst_x == cfg.coord_x) && (hdr.dst_y == cfg.coord_y);

	always_comb begin
		uni_mask = '0;
		uni_wrap = 1'b0;
		priority if (at_dst) begin
			uni_mask[PORT_LOCAL] = 1'b1;
		end else if (!net1 && (cfg.coord_x != hdr.dst_x)) begin
			uni_mask[PORT_EAST] = 1'b1;
			uni_wrap = (w > SIZE_W'(1)) && (SIZE_W'(cfg.coord_x) == w_last) &&
				(SIZE_W'(hdr.dst_x) != w_last);
		end else if (!net1) begin
			uni_mask[PORT_SOUTH] = 1'b1;
			uni_wrap = (h > SIZE_W'(1)) && (SIZE_W'(cfg.coord_y) == h_last) &&
				(SIZE_W'(hdr.dst_y) != h_last);
		end else if (cfg.coord_y != hdr.dst_y) begin
			uni_mask[PORT_NORTH] = 1'b1;
			uni_wrap = (h > SIZE_W'(1)) && (cfg.coord_y == '0) && (hdr.dst_y != '0);
		end else begin
			uni_mask[PORT_WEST] = 1'b1;
			uni_wrap = (w > SIZE_W'(1)) && (cfg.coord_x == '0) && (hdr.dst_x != '0);
		end
	end

	// Broadcast: span membership and positions still to reach
	assign ix = (w != '0) && in_span(hdr.span_start_x, hdr.span_end_x, cfg.coord_x);
	assign iy = (h != '0) && in_span(hdr.span_start_y, hdr.span_end_y, cfg.coord_y);
	assign xa = ahead(cfg.coord_x, hdr.span_start_x, hdr.span_end_x, w);
	assign ya = ahead(cfg.coord_y, hdr.span_start_y, hdr.span_end_y, h);
	assign at_src = (cfg.coord_x == hdr.src_x) && (cfg.coord_y == hdr.src_y);

	// Major dimension spreads from the source line, minor inside the major span
	assign x_fwd = hdr.column_first ? (iy && xa) : (((cfg.coord_y == hdr.src_y) || iy) && xa);
	assign y_fwd = hdr.column_first ? (((cfg.coord_x == hdr.src_x) || ix) && ya) : (ix && ya);

	always_comb begin
		bc_mask = '0;
		bc_mask[PORT_LOCAL] = ix && iy && (hdr.include_source || !at_src);
		bc_mask[PORT_WEST]  = net1 && x_fwd;
		bc_mask[PORT_EAST]  = !net1 && x_fwd;
		bc_mask[PORT_NORTH] = net1 && y_fwd;
		bc_mask[PORT_SOUTH] = !net1 && y_fwd;
	end

	assign res.port_mask = hdr.bcast ? bc_mask : uni_mask;
	assign res.wrap      = !hdr.bcast && uni_wrap;
endmodule

/* rtl/core/trm_checker.sv */
// Port checker for the torus route and multicast mask, bound to the top level.
`include "torus_route_and_multicast_mask_macros.svh"

module trm_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      hdr_valid,
	input logic                      hdr_ready,
	input logic                      route_valid,
	input logic                      route_ready,
	input logic [trm_pkg::PORT_N-1:0] port_mask,
	input logic                      wrap,
	input logic                      cfg_valid,
	input logic                      cfg_ready
);
	import trm_pkg::*;

	logic hdr_acc;
	logic route_stall;

	assign hdr_acc     = hdr_valid && hdr_ready;
	assign route_stall = route_valid && !route_ready;

	// A stalled result holds still
	`TRM_ASSERT_NEXT(a_route_hold, route_stall, route_valid && $stable(port_mask) && $stable(wrap))
	// Every accepted header is followed by a valid result on route
	`TRM_ASSERT_SAME(a_latency, hdr_acc, ##2 route_valid)
	// With no result pending the header side cannot be blocked
	`TRM_ASSERT_SAME(a_no_block, !route_valid, hdr_ready)
	// Wrap only on a unicast hop to a neighbor port
	`TRM_ASSERT_SAME(a_wrap_hop, route_valid && wrap, $onehot(port_mask) && !port_mask[PORT_LOCAL])
	// Register writes are never refused
	`TRM_ASSERT_SAME(a_cfg_ready, cfg_valid, cfg_ready)
endmodule

bind torus_route_and_multicast_mask trm_checker u_trm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.hdr_valid   (hdr.valid),
	.hdr_ready   (hdr.ready),
	.route_valid (route.valid),
	.route_ready (route.ready),
	.port_mask   (route.port_mask),
	.wrap        (route.wrap),
	.cfg_valid   (cfg.valid),
	.cfg_ready   (cfg.ready)
);
